// ===== rtl/core/gce_pkg.sv =====
// shared types and constants of the gradient colormap evaluator
`default_nettype none

package gce_pkg;

	// item kinds carried on the input tuser bit
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// register word index of the mark count
	localparam logic REG_MARK_COUNT = 1'b0;

	// width of the mark count and of the scan index
	localparam int CNT_W = 5;
	// color channels per mark
	localparam int NUM_CH = 3;
	// quotient bits produced by the divider
	localparam int DIV_STEPS = 8;

	// commands from the controller to the datapath
	typedef struct packed {
		logic             wr_en;
		logic             start;
		logic             rd_en;
		logic [CNT_W-1:0] rd_idx;
		logic             check;
		logic             mul_en;
		logic             div_init;
		logic             div_step;
		logic             out_load;
		logic             empty;
	} gce_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic above;
	} gce_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/gce_ctrl.sv =====
// controller state machine: scan sequencing, divide steps and result handshake
`default_nettype none

module gce_ctrl
	import gce_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_op,
	output logic                  in_ready,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire logic [CNT_W-1:0] count,
	input  gce_sts_t              sts,
	output gce_cmd_t              cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_INIT,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] idx_q;
	logic             chk_q;
	logic             last_q;
	logic [2:0]       step_q;
	logic             empty_q;
	logic             out_valid_q;
	logic             accept;
	logic             can_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign can_load  = !out_valid_q || out_ready;

	// datapath commands
	always_comb begin
		cmd          = '0;
		cmd.wr_en    = accept && (in_op == OP_WRITE);
		cmd.start    = accept && (in_op == OP_LOOKUP);
		cmd.rd_en    = (state_q == ST_SCAN);
		cmd.rd_idx   = idx_q;
		cmd.check    = (state_q == ST_SCAN) && chk_q;
		cmd.mul_en   = (state_q == ST_MUL);
		cmd.div_init = (state_q == ST_INIT);
		cmd.div_step = (state_q == ST_DIV);
		cmd.out_load = (state_q == ST_FIN) && can_load;
		cmd.empty    = empty_q;
	end

	// state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			chk_q       <= 1'b0;
			last_q      <= 1'b0;
			step_q      <= '0;
			empty_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// result valid: set on load, cleared when taken
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						idx_q  <= '0;
						chk_q  <= 1'b0;
						last_q <= 1'b0;
						if (count == '0) begin
							empty_q <= 1'b1;
							state_q <= ST_FIN;
						end else begin
							empty_q <= 1'b0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					// one read issued per cycle, each checked in the cycle after
					chk_q  <= (idx_q < count);
					last_q <= (idx_q == count - CNT_W'(1));
					idx_q  <= idx_q + CNT_W'(1);
					if (chk_q && (sts.above || last_q))
						state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'(DIV_STEPS - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (can_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gce_datapath.sv =====
// datapath: mark memory, left and right mark registers, multipliers, serial dividers
`default_nettype none

module gce_datapath
	import gce_pkg::*;
#(
	parameter int MAX_MARKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  gce_cmd_t         cmd,
	output gce_sts_t         sts,
	input  wire logic [3:0]  slot,
	input  wire logic [31:0] mark_word,
	input  wire logic [7:0]  level,
	output logic      [23:0] res_color,
	output logic             res_empty
);

	localparam int IDX_W = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
	localparam logic [8:0] MAX_V = 9'(MAX_MARKS);

	logic [31:0] mem [MAX_MARKS];
	logic [31:0] rd_data_q;
	logic [7:0]  level_q;
	logic [31:0] left_q;
	logic [31:0] right_q;
	logic        has_left_q;
	logic        has_right_q;
	logic [15:0] pa_s1 [NUM_CH];
	logic [15:0] pb_s1 [NUM_CH];
	logic [7:0]  d_s1;
	logic [7:0]  rem_q [NUM_CH];
	logic [7:0]  quo_q [NUM_CH];
	logic [7:0]  pos;
	logic [7:0]  w_left;
	logic [7:0]  w_right;

	assign pos       = rd_data_q[31:24];
	assign sts.above = (pos > level_q);

	// mark memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en && ({5'b0, slot} < MAX_V))
			mem[IDX_W'(slot)] <= mark_word;
		if (cmd.rd_en)
			rd_data_q <= mem[IDX_W'(cmd.rd_idx)];
	end

	// scan bookkeeping: last mark at or below the level, first above
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_left_q  <= 1'b0;
			has_right_q <= 1'b0;
		end else if (cmd.start) begin
			has_left_q  <= 1'b0;
			has_right_q <= 1'b0;
		end else if (cmd.check) begin
			if (sts.above)
				has_right_q <= 1'b1;
			else
				has_left_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start)
			level_q <= level;
		if (cmd.check) begin
			if (sts.above)
				right_q <= rd_data_q;
			else
				left_q <= rd_data_q;
		end
	end

	// weights: left by (pR - level), right by (level - pL)
	assign w_left  = right_q[31:24] - level_q;
	assign w_right = level_q - left_q[31:24];

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			d_s1 <= right_q[31:24] - left_q[31:24];
			for (int k = 0; k < NUM_CH; k++) begin
				pa_s1[k] <= {8'd0, left_q[8*k +: 8]} * {8'd0, w_left};
				pb_s1[k] <= {8'd0, right_q[8*k +: 8]} * {8'd0, w_right};
			end
		end
	end

	// restoring divide, one quotient bit per cycle on each channel
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			for (int k = 0; k < NUM_CH; k++) begin
				rem_q[k] <= 8'((pa_s1[k] + pb_s1[k]) >> 8);
				quo_q[k] <= 8'(pa_s1[k] + pb_s1[k]);
			end
		end else if (cmd.div_step) begin
			for (int k = 0; k < NUM_CH; k++) begin
				if ({rem_q[k], quo_q[k][7]} >= {1'b0, d_s1}) begin
					rem_q[k] <= 8'({rem_q[k], quo_q[k][7]} - {1'b0, d_s1});
					quo_q[k] <= {quo_q[k][6:0], 1'b1};
				end else begin
					rem_q[k] <= {rem_q[k][6:0], quo_q[k][7]};
					quo_q[k] <= {quo_q[k][6:0], 1'b0};
				end
			end
		end
	end

	// result register: black when empty, the nearest mark past either end, else the quotient
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_empty <= cmd.empty;
			for (int k = 0; k < NUM_CH; k++) begin
				if (cmd.empty)
					res_color[8*k +: 8] <= 8'd0;
				else if (!has_left_q)
					res_color[8*k +: 8] <= right_q[8*k +: 8];
				else if (!has_right_q)
					res_color[8*k +: 8] <= left_q[8*k +: 8];
				else
					res_color[8*k +: 8] <= quo_q[k];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/gradient_colormap_eval.sv =====
// Piecewise-linear color gradient evaluator, top level.
// Input stream (s_*): a beat with s_tuser = 0 writes one color mark into a
// slot and gives no result; s_tuser = 1 looks up a level and gives one
// result beat on the output stream (m_*) with the interpolated RGB color.
// The APB port holds mark_count, the number of slots scanned from slot 0.
// A write beat leaves the input ready for the next beat. A lookup scans
// marks from slot 0 and stops at the first mark above the level or at the
// last mark in use, and the input stays closed until its result is loaded. The scan
// reads one mark per cycle from the single read port of the mark memory,
// and an eight-step restoring divider runs on the three channels at once.
// The next beat is accepted as soon as the result is loaded into the output
// register, even while the receiver still holds m_tready low; a finished
// lookup waits only if the previous result has not been taken.
// Reset clears mark_count and the handshake state; mark memory contents
// are undefined until written.
`default_nettype none

module gradient_colormap_eval
	import gce_pkg::*;
#(
	parameter int MAX_MARKS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// slot[3:0], mark_red[11:4], mark_green[19:12], mark_blue[27:20],
	// mark_position[35:28], level[43:36], zero fill [47:44]
	input  wire logic [47:0] s_tdata,
	// op[0]
	input  wire logic        s_tuser,
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// out_red[7:0], out_green[15:8], out_blue[23:16]
	output logic      [23:0] m_tdata,
	// empty_res[0]
	output logic             m_tuser,
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam logic [8:0] MAX_V = 9'(MAX_MARKS);

	logic [CNT_W-1:0] mark_count_q;
	logic [CNT_W-1:0] count_eff;
	gce_cmd_t         cmd;
	gce_sts_t         sts;

	// register file
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MARK_COUNT) ? {27'd0, mark_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mark_count_q <= '0;
		else if (psel && penable && pwrite && pready && (paddr[2] == REG_MARK_COUNT))
			mark_count_q <= pwdata[CNT_W-1:0];
	end

	// counts above capacity scan the whole store
	assign count_eff = ({4'd0, mark_count_q} > MAX_V) ? CNT_W'(MAX_MARKS) : mark_count_q;

	gce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_op     (s_tuser),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.count     (count_eff),
		.sts       (sts),
		.cmd       (cmd)
	);

	gce_datapath #(
		.MAX_MARKS (MAX_MARKS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.slot      (s_tdata[3:0]),
		.mark_word ({s_tdata[35:28], s_tdata[27:20], s_tdata[19:12], s_tdata[11:4]}),
		.level     (s_tdata[43:36]),
		.res_color (m_tdata),
		.res_empty (m_tuser)
	);

endmodule

`default_nettype wire

// ===== rtl/core/gce_checker.sv =====
// port-level checks of the gradient colormap evaluator and their binding
`default_nettype none

module gce_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser
);

	// a lookup keeps the input closed in the following cycle
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> !s_tready)
		else $error("input open right after a lookup beat");

	// a write beat never produces a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !s_tuser && !m_tvalid) |=> !m_tvalid)
		else $error("result beat after a write beat");

	// an empty result is black
	a_empty_black: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == 24'd0))
		else $error("empty result with nonzero color");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result beat changed while stalled");

endmodule

bind gradient_colormap_eval gce_checker u_gce_checker (.*);

`default_nettype wire

// ===== tb/tb_gradient_colormap_eval.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the gradient colormap evaluator with its own color predictor

module tb_gradient_colormap_eval;
	import gce_pkg::*;

	localparam int NUM_SLOTS    = 16;
	localparam int RANDOM_BEATS = 600;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT  = 3000;
	localparam int LONG_HOLD    = 400;
	localparam logic [2:0] ADDR_MARK_COUNT = {REG_MARK_COUNT, 2'b00};

	// one stored mark, laid out as in the block's store
	typedef struct packed {
		logic [7:0] position;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} mark_t;

	// one expected color beat
	typedef struct packed {
		logic       empty;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} color_t;

	// one input beat before packing
	typedef struct packed {
		logic       op;
		logic [3:0] slot;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] position;
		logic [7:0] level;
	} beat_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// slot[3:0], mark_red[11:4], mark_green[19:12], mark_blue[27:20],
	// mark_position[35:28], level[43:36], zero fill [47:44]
	logic [47:0] s_tdata  = '0;
	// op[0]
	logic        s_tuser  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// out_red[7:0], out_green[15:8], out_blue[23:16]
	logic [23:0] m_tdata;
	// empty_res[0]
	logic        m_tuser;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [2:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state and the store of expected colors
	mark_t            mark_mem [NUM_SLOTS];
	logic [CNT_W-1:0] tb_count = '0;
	color_t           color_q [$];
	beat_t            beat_q [$];

	int beats_queued   = 0;
	int beats_taken    = 0;
	int colors_checked = 0;
	int err_cnt        = 0;
	int settings_cnt   = 0;

	gradient_colormap_eval dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// truncated blend of one channel between two marks
	function automatic logic [7:0] blend(input int unsigned cl, cr, n, d);
		return 8'((cl * (d - n) + cr * n) / d);
	endfunction

	// color of the gradient at a level, from the current marks and count
	function automatic color_t eval_gradient(input logic [7:0] level);
		color_t      res;
		mark_t       lm, rm;
		logic        has_l, has_r;
		int unsigned scan, n, d;
		res   = '0;
		lm    = '0;
		rm    = '0;
		has_l = 1'b0;
		has_r = 1'b0;
		scan  = (tb_count > NUM_SLOTS) ? NUM_SLOTS : 32'(tb_count);
		if (scan == 0) begin
			res.empty = 1'b1;
			return res;
		end
		// left mark is the last one at or below the level before the first above
		for (int j = 0; j < scan && !has_r; j++) begin
			if (mark_mem[j].position <= level) begin
				has_l = 1'b1;
				lm    = mark_mem[j];
			end else begin
				has_r = 1'b1;
				rm    = mark_mem[j];
			end
		end
		if (!has_l) begin
			res.red   = rm.red;
			res.green = rm.green;
			res.blue  = rm.blue;
		end else if (!has_r) begin
			res.red   = lm.red;
			res.green = lm.green;
			res.blue  = lm.blue;
		end else begin
			n = 32'(level - lm.position);
			d = 32'(rm.position - lm.position);
			res.red   = blend(lm.red, rm.red, n, d);
			res.green = blend(lm.green, rm.green, n, d);
			res.blue  = blend(lm.blue, rm.blue, n, d);
		end
		return res;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endtask

	function automatic beat_t rand_beat();
		beat_t b;
		b.op       = 1'($urandom_range(0, 1));
		b.slot     = 4'($urandom_range(0, NUM_SLOTS - 1));
		b.red      = 8'($urandom_range(0, 255));
		b.green    = 8'($urandom_range(0, 255));
		b.blue     = 8'($urandom_range(0, 255));
		b.position = 8'($urandom_range(0, 255));
		b.level    = 8'($urandom_range(0, 255));
		return b;
	endfunction

	task automatic queue_beat(input beat_t b);
		beat_q = {beat_q, b};
		beats_queued++;
	endtask

	// wait until every beat is taken and every color has come back
	task automatic drain();
		while (!(beats_taken == beats_queued && color_q.size() == 0))
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write: setup cycle, then access cycle until pready
	task automatic cfg_write(input logic [CNT_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_MARK_COUNT;
		pwdata  <= {{(32 - CNT_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tb_count = value;
		settings_cnt++;
	endtask

	// sender: bursts of beats with random gaps, occasionally a long gapless run
	int burst_left = 0;
	int gap_left   = 0;
	always @(posedge clk) begin : drive_beats
		beat_t nb;
		if (arst_n && (!s_tvalid || s_tready)) begin
			if (gap_left > 0 || beat_q.size() == 0) begin
				if (gap_left > 0)
					gap_left--;
				s_tvalid <= 1'b0;
			end else begin
				nb = beat_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= nb.op;
				s_tdata  <= {4'b0000, nb.level, nb.position, nb.blue, nb.green, nb.red, nb.slot};
				if (burst_left > 1) begin
					burst_left--;
				end else if ($urandom_range(0, 5) == 0) begin
					burst_left = 40;
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left   = $urandom_range(0, 6);
				end
			end
		end
	end

	// receiver: random stall patterns, one long hold-off
	rx_mode_t rx_mode   = RX_OPEN;
	int       rx_left   = 0;
	int       hold_left = 0;
	logic     hold_done = 1'b0;
	always @(posedge clk) begin : drive_ready
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (!hold_done && colors_checked >= 100 && beat_q.size() > 4) begin
			hold_done = 1'b1;
			hold_left = LONG_HOLD;
			m_tready <= 1'b0;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(10, 80);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				RX_OPEN:   m_tready <= 1'b1;
				RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
				RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
				default:   m_tready <= (rx_left % 3 != 0);
			endcase
		end
	end

	// monitor: update marks on write beats, predict on lookups, check color beats
	always @(posedge clk) begin : watch_beats
		color_t want;
		if (s_tvalid && s_tready) begin
			beats_taken++;
			if (s_tuser == OP_WRITE)
				mark_mem[s_tdata[3:0]] = s_tdata[35:4];
			else
				color_q = {color_q, eval_gradient(s_tdata[43:36])};
		end
		if (m_tvalid && m_tready) begin
			if (color_q.size() == 0) begin
				$error("color beat with no lookup pending: tdata %h tuser %b", m_tdata, m_tuser);
				err_cnt++;
			end else begin
				want = color_q.pop_front();
				check_field("out_red", want.red, m_tdata[7:0]);
				check_field("out_green", want.green, m_tdata[15:8]);
				check_field("out_blue", want.blue, m_tdata[23:16]);
				check_field("empty_res", {7'b0, want.empty}, {7'b0, m_tuser});
				colors_checked++;
			end
		end
	end

	// watchdog on cycles with no beat and no register access
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("timeout after %0d quiet cycles", quiet_cycles);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin : stimulus
		beat_t      b;
		int         eff, nbeats, pos, step, random_beats;
		int         phase_pos [NUM_SLOTS];
		logic [4:0] count_pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// no marks in use: black with the empty flag, at both ends of the level range
		for (int i = 0; i < 2; i++) begin
			b       = rand_beat();
			b.op    = OP_LOOKUP;
			b.level = i ? 8'hff : 8'h00;
			queue_beat(b);
		end
		// full sorted gradient over every slot, colors at both extremes
		for (int i = 0; i < NUM_SLOTS; i++) begin
			b          = rand_beat();
			b.op       = OP_WRITE;
			b.slot     = 4'(i);
			b.position = 8'(i * 17);
			b.red      = i[0] ? 8'hff : 8'h00;
			b.green    = 8'(255 - i * 17);
			b.blue     = 8'(i * 17);
			queue_beat(b);
		end
		drain();
		// all slots in use: first mark, last mark, exact hit, between two marks
		cfg_write(5'(NUM_SLOTS));
		for (int i = 0; i < 4; i++) begin
			b       = rand_beat();
			b.op    = OP_LOOKUP;
			b.level = (i == 0) ? 8'd0 : (i == 1) ? 8'd255 : (i == 2) ? 8'd85 : 8'd93;
			queue_beat(b);
		end
		drain();
		// count above capacity acts as a full store
		cfg_write(5'd31);
		b       = rand_beat();
		b.op    = OP_LOOKUP;
		b.level = 8'd130;
		queue_beat(b);
		drain();
		// single mark: below it there is no left mark, above it no right mark
		cfg_write(5'd1);
		b          = rand_beat();
		b.op       = OP_WRITE;
		b.slot     = 4'd0;
		b.position = 8'd100;
		queue_beat(b);
		for (int i = 0; i < 2; i++) begin
			b       = rand_beat();
			b.op    = OP_LOOKUP;
			b.level = i ? 8'd200 : 8'd50;
			queue_beat(b);
		end
		drain();

		// random phases, each under one mark count
		random_beats = 0;
		while (random_beats < RANDOM_BEATS) begin
			case ($urandom_range(0, 7))
				0:       count_pick = 5'd0;
				1:       count_pick = 5'd1;
				2:       count_pick = 5'(NUM_SLOTS);
				3:       count_pick = 5'($urandom_range(NUM_SLOTS + 1, 31));
				default: count_pick = 5'($urandom_range(2, NUM_SLOTS));
			endcase
			cfg_write(count_pick);
			eff = (count_pick > NUM_SLOTS) ? NUM_SLOTS : int'(count_pick);
			if ($urandom_range(0, 3) != 0) begin
				// sorted marks over the slots in use with random colors, then lookups
				pos  = $urandom_range(0, 64);
				step = (eff > 0) ? 384 / eff : 0;
				for (int i = 0; i < eff; i++) begin
					b            = rand_beat();
					b.op         = OP_WRITE;
					b.slot       = 4'(i);
					b.position   = 8'(pos);
					phase_pos[i] = pos;
					queue_beat(b);
					random_beats++;
					pos = pos + $urandom_range(0, step);
					if (pos > 255)
						pos = 255;
				end
				nbeats = $urandom_range(6, 20);
				for (int i = 0; i < nbeats; i++) begin
					b    = rand_beat();
					b.op = OP_LOOKUP;
					case ($urandom_range(0, 7))
						0: b.level = 8'h00;
						1: b.level = 8'hff;
						2, 3: begin
							if (eff > 0)
								b.level = 8'(phase_pos[$urandom_range(0, eff - 1)]);
						end
						default: ;
					endcase
					queue_beat(b);
					random_beats++;
				end
			end else begin
				// noise: writes and lookups mixed, marks left unsorted
				nbeats = $urandom_range(4, 24);
				for (int i = 0; i < nbeats; i++) begin
					queue_beat(rand_beat());
					random_beats++;
				end
			end
			drain();
		end

		$display("run took %0d input beats under %0d mark count settings", beats_taken,
			settings_cnt);
		$display("%0d color beats compared, %0d mismatches", colors_checked, err_cnt);
		if (err_cnt == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
